FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// ASSERT_IMPL: same-cycle implication, ASSERT_NEXT: next-cycle implication.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/sfgb_pkg.sv
// ----------------------------------------------------------------------------
// sfgb_pkg
// Shared constants and types of the serial frame GPIO command bridge.
// ----------------------------------------------------------------------------
package sfgb_pkg;

    localparam int RING_DEPTH_DEF = 8;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [7:0] CH_STX     = 8'h02;
    localparam logic [7:0] CH_ETX     = 8'h03;
    localparam logic [7:0] CH_ACK     = 8'h06;
    localparam logic [7:0] CMD_START  = 8'd1;
    localparam logic [7:0] CMD_STOP   = 8'd4;
    localparam logic [7:0] CMD_OUT    = 8'd65;
    localparam logic [7:0] CMD_AUX    = 8'd88;
    localparam logic [7:0] CMD_READ   = 8'd82;
    localparam logic [7:0] CMD_STATUS = 8'd83;
    localparam logic [7:0] SEL_MAIN   = 8'd81;
    localparam logic [7:0] SEL_AUX    = 8'd65;
    localparam logic [2:0] AUX_INVERT = 3'b111;

    // One classified request, as handed from front to back
    typedef struct packed {
        logic       send;
        logic [7:0] cmd;
        logic [7:0] data;
        logic [5:0] main_level;
        logic [2:0] aux_level;
        logic       running;
    } sfgb_item_t;

endpackage

FILE: hw/rtl/sfgb_front.sv
// ----------------------------------------------------------------------------
// sfgb_front
// Receive ring, frame detection, command execution and request classification.
// ----------------------------------------------------------------------------
module sfgb_front #(
    parameter int RING_DEPTH = sfgb_pkg::RING_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                q_full,
    input  logic [7:0]          rx_byte,
    input  logic [5:0]          main_pins_in,
    input  logic [2:0]          aux_pins_in,
    output logic                push,
    output sfgb_pkg::sfgb_item_t push_item
);
    import sfgb_pkg::*;

    localparam int PW = $clog2(RING_DEPTH);
    localparam logic [PW-1:0] IDX1 = PW'(RING_DEPTH - 1);
    localparam logic [PW-1:0] IDX2 = PW'(RING_DEPTH - 2);
    localparam logic [PW-1:0] IDX3 = PW'(RING_DEPTH - 3);

    logic [7:0]    ring_reg [RING_DEPTH];
    logic [PW-1:0] pos_reg, pos_next;
    // win<k> holds the ring entry k places behind the write position
    logic [7:0]    win1_reg, win1_next;
    logic [7:0]    win2_reg, win2_next;
    logic [7:0]    win3_reg, win3_next;
    logic [5:0]    main_level_reg, main_level_next;
    logic [2:0]    aux_level_reg, aux_level_next;
    logic          running_reg, running_next;
    logic          frame;
    logic          send;
    logic [7:0]    data;

    assign push  = in_valid && !q_full;
    assign frame = (rx_byte == CH_ETX) && (win3_reg == CH_STX);

    always_comb
    begin
        pos_next        = pos_reg;
        win1_next       = win1_reg;
        win2_next       = win2_reg;
        win3_next       = win3_reg;
        main_level_next = main_level_reg;
        aux_level_next  = aux_level_reg;
        running_next    = running_reg;
        send            = 1'b0;
        data            = CH_ACK;
        if (push)
        begin
            if (frame)
            begin
                pos_next  = '0;
                // window for position 0, bypassing this cycle's write
                win1_next = (pos_reg == IDX1) ? rx_byte : ring_reg[IDX1];
                win2_next = (pos_reg == IDX2) ? rx_byte : ring_reg[IDX2];
                win3_next = (pos_reg == IDX3) ? rx_byte : ring_reg[IDX3];
                case (win2_reg)
                    CMD_START:
                    begin
                        running_next = 1'b1;
                    end
                    CMD_STOP:
                    begin
                        running_next = 1'b0;
                    end
                    CMD_OUT:
                    begin
                        main_level_next = ~win1_reg[5:0];
                        send            = 1'b1;
                    end
                    CMD_AUX:
                    begin
                        aux_level_next = win1_reg[2:0];
                        send           = 1'b1;
                    end
                    CMD_READ:
                    begin
                        if (win1_reg == SEL_MAIN)
                        begin
                            send = 1'b1;
                            data = {2'b00, main_pins_in};
                        end
                        else if (win1_reg == SEL_AUX)
                        begin
                            send = 1'b1;
                            data = {5'b00000, aux_pins_in ^ AUX_INVERT};
                        end
                    end
                    CMD_STATUS:
                    begin
                        send = 1'b1;
                    end
                    default:
                    begin
                        send = 1'b0;
                    end
                endcase
            end
            else
            begin
                pos_next  = (pos_reg == IDX1) ? '0 : pos_reg + 1'b1;
                win1_next = rx_byte;
                win2_next = win1_reg;
                win3_next = win2_reg;
            end
        end
    end

    always_comb
    begin
        push_item.send       = send;
        push_item.cmd        = win2_reg;
        push_item.data       = data;
        push_item.main_level = main_level_next;
        push_item.aux_level  = aux_level_next;
        push_item.running    = running_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
            pos_reg        <= '0;
            win1_reg       <= '0;
            win2_reg       <= '0;
            win3_reg       <= '0;
            main_level_reg <= 6'h3f;
            aux_level_reg  <= '0;
            running_reg    <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                ring_reg[pos_reg] <= rx_byte;
            end
            pos_reg        <= pos_next;
            win1_reg       <= win1_next;
            win2_reg       <= win2_next;
            win3_reg       <= win3_next;
            main_level_reg <= main_level_next;
            aux_level_reg  <= aux_level_next;
            running_reg    <= running_next;
        end
    end

endmodule

FILE: hw/rtl/sfgb_queue.sv
// ----------------------------------------------------------------------------
// sfgb_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module sfgb_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sfgb_pkg::sfgb_item_t push_item,
    input  logic                pop,
    output logic                full,
    output logic                q_valid,
    output sfgb_pkg::sfgb_item_t q_item
);
    import sfgb_pkg::*;

    localparam int QPW = $clog2(QUEUE_DEPTH);

    sfgb_item_t     entries_reg [QUEUE_DEPTH];
    logic [QPW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPW:0]   count_reg, count_next;

    assign full    = (count_reg == (QPW+1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPW+1)'(push) - (QPW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hw/rtl/sfgb_back.sv
// ----------------------------------------------------------------------------
// sfgb_back
// Expands queued requests into response bytes through an output register.
// ----------------------------------------------------------------------------
module sfgb_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  sfgb_pkg::sfgb_item_t q_item,
    output logic                pop,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [7:0]          tx_byte,
    output logic                tx_valid,
    output logic                last,
    output logic [5:0]          main_out_level,
    output logic [2:0]          aux_out_level,
    output logic                running
);
    import sfgb_pkg::*;
    `include "assert_macros.svh"

    localparam logic [1:0] BEAT_STX  = 2'd0;
    localparam logic [1:0] BEAT_CMD  = 2'd1;
    localparam logic [1:0] BEAT_DATA = 2'd2;
    localparam logic [1:0] BEAT_ETX  = 2'd3;

    logic       advance;
    logic [1:0] beat_reg, beat_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] tx_byte_reg, tx_byte_next;
    logic       tx_valid_reg, tx_valid_next;
    logic       last_reg, last_next;
    logic [5:0] main_reg, main_next;
    logic [2:0] aux_reg, aux_next;
    logic       running_reg, running_next;

    // output slot is free or being emptied this cycle
    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && q_valid && (!q_item.send || beat_reg == BEAT_ETX);

    always_comb
    begin
        beat_next      = beat_reg;
        out_valid_next = out_valid_reg;
        tx_byte_next   = tx_byte_reg;
        tx_valid_next  = tx_valid_reg;
        last_next      = last_reg;
        main_next      = main_reg;
        aux_next       = aux_reg;
        running_next   = running_reg;
        if (advance)
        begin
            out_valid_next = q_valid;
            if (q_valid)
            begin
                main_next    = q_item.main_level;
                aux_next     = q_item.aux_level;
                running_next = q_item.running;
                if (q_item.send)
                begin
                    tx_valid_next = 1'b1;
                    last_next     = (beat_reg == BEAT_ETX);
                    beat_next     = beat_reg + 1'b1;
                    case (beat_reg)
                        BEAT_STX:  tx_byte_next = CH_STX;
                        BEAT_CMD:  tx_byte_next = q_item.cmd;
                        BEAT_DATA: tx_byte_next = q_item.data;
                        BEAT_ETX:  tx_byte_next = CH_ETX;
                        default:   tx_byte_next = CH_STX;
                    endcase
                end
                else
                begin
                    // status-only result
                    tx_byte_next  = '0;
                    tx_valid_next = 1'b0;
                    last_next     = 1'b1;
                    beat_next     = BEAT_STX;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg      <= BEAT_STX;
            out_valid_reg <= 1'b0;
            tx_byte_reg   <= '0;
            tx_valid_reg  <= 1'b0;
            last_reg      <= 1'b0;
            main_reg      <= 6'h3f;
            aux_reg       <= '0;
            running_reg   <= 1'b0;
        end
        else
        begin
            beat_reg      <= beat_next;
            out_valid_reg <= out_valid_next;
            tx_byte_reg   <= tx_byte_next;
            tx_valid_reg  <= tx_valid_next;
            last_reg      <= last_next;
            main_reg      <= main_next;
            aux_reg       <= aux_next;
            running_reg   <= running_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign tx_byte        = tx_byte_reg;
    assign tx_valid       = tx_valid_reg;
    assign last           = last_reg;
    assign main_out_level = main_reg;
    assign aux_out_level  = aux_reg;
    assign running        = running_reg;

    // a frame in progress keeps its request at the queue head
    `ASSERT_IMPL(a_beat_has_item, clk, rst_n, beat_reg != BEAT_STX, q_valid)
    // only frame bytes can be non-final
    `ASSERT_IMPL(a_nonlast_is_tx, clk, rst_n, out_valid_reg && !last_reg, tx_valid_reg)
    // closing beat of a frame is flagged last
    `ASSERT_NEXT(a_etx_last, clk, rst_n,
                 advance && q_valid && q_item.send && beat_reg == BEAT_ETX,
                 out_valid_reg && last_reg && tx_byte_reg == CH_ETX)

endmodule

FILE: hw/rtl/serial_frame_gpio_command_bridge.sv
// ----------------------------------------------------------------------------
// serial_frame_gpio_command_bridge
// Framed serial byte commands to GPIO levels, with response frames.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry one received byte plus sampled main
// and aux pin levels. Output channel: out_valid/out_stall carry one result:
// a response byte (tx_valid high) or a status-only result, with the current
// output levels and running flag.
// A request that completes a frame with 'A', 'X', 'S' or a valid 'R' yields
// four results (STX, command, ACK/data, ETX), last on the fourth; any other
// request yields one status-only result with last set.
// The first result of a request passes through the queue and the output register.
// The output register presents one result per cycle while out_stall is low;
// a frame request keeps its queue entry until its fourth result is loaded.
// The front accepts a request every cycle while the 4-entry request queue
// has room; in_stall rises only when that queue is full.
// With out_valid and out_stall high, the output holds and the queue fills.
// Reset clears the receive ring and position, sets the main levels to all
// ones, aux levels and running to zero, and empties queue and output.
// ----------------------------------------------------------------------------
module serial_frame_gpio_command_bridge #(
    parameter int RING_DEPTH = sfgb_pkg::RING_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic [5:0] main_pins_in,
    input  logic [2:0] aux_pins_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] tx_byte,
    output logic       tx_valid,
    output logic       last,
    output logic [5:0] main_out_level,
    output logic [2:0] aux_out_level,
    output logic       running
);
    import sfgb_pkg::*;

    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_valid;
    sfgb_item_t push_item;
    sfgb_item_t q_item;

    assign in_stall = q_full;

    sfgb_front #(
        .RING_DEPTH (RING_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .q_full       (q_full),
        .rx_byte      (rx_byte),
        .main_pins_in (main_pins_in),
        .aux_pins_in  (aux_pins_in),
        .push         (push),
        .push_item    (push_item)
    );

    sfgb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    sfgb_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .pop            (pop),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .tx_byte        (tx_byte),
        .tx_valid       (tx_valid),
        .last           (last),
        .main_out_level (main_out_level),
        .aux_out_level  (aux_out_level),
        .running        (running)
    );

endmodule
